FILE: hw/rtl/fpu_pkg.sv
// Package for the single-precision arithmetic unit.
// Holds the operation codes, the task record passed from front to back, and constants.
package fpu_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // Kind of work that the back end has to do for one item.
  typedef enum logic [1:0] {
    K_FIXED = 2'd0,
    K_ADD   = 2'd1,
    K_MUL   = 2'd2,
    K_DIV   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_ALGN = 3'd1,
    S_NORM = 3'd2,
    S_DIVI = 3'd3,
    S_PACK = 3'd4,
    S_DONE = 3'd5
  } bst_e;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam int unsigned BIAS = 127;

  // Classified item: either a finished answer or unpacked operands.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] fixed;
    logic        sa;
    logic        sb;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
  } task_t;

endpackage

FILE: hw/rtl/fpu_front.sv
// Front end: accepts an item, screens special operands and unpacks the rest.
// Depends on fpu_pkg.
module fpu_front import fpu_pkg::*; (
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output task_t       task_o
);

  logic        sa, sb, s;
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, z_a, z_b;

  always_comb begin
    sa = operand_a_i[31];
    sb = operand_b_i[31] ^ (cmd_i == OP_SUB);
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    nan_a = (ea == 8'hFF) && (fa != '0);
    nan_b = (eb == 8'hFF) && (fb != '0);
    inf_a = (ea == 8'hFF) && (fa == '0);
    inf_b = (eb == 8'hFF) && (fb == '0);
    z_a = (ea == 8'h00);
    z_b = (eb == 8'h00);
    s = sa ^ sb;
    task_o.kind  = K_FIXED;
    task_o.fixed = CANON_NAN;
    task_o.sa = sa;
    task_o.sb = sb;
    task_o.ea = ea;
    task_o.eb = eb;
    task_o.ma = {1'b1, fa};
    task_o.mb = {1'b1, fb};
    // Special operands are answered here; the back end only passes them on.
    unique case (op_e'(cmd_i))
      OP_ADD, OP_SUB: begin
        if (nan_a || nan_b) task_o.fixed = CANON_NAN;
        else if (inf_a && inf_b) task_o.fixed = (sa == sb) ? {sa, 8'hFF, 23'd0} : CANON_NAN;
        else if (inf_a) task_o.fixed = {sa, 8'hFF, 23'd0};
        else if (inf_b) task_o.fixed = {sb, 8'hFF, 23'd0};
        else if (z_a && z_b) task_o.fixed = {sa & sb, 31'd0};
        else if (z_a) task_o.fixed = {sb, operand_b_i[30:0]};
        else if (z_b) task_o.fixed = operand_a_i;
        else task_o.kind = K_ADD;
      end
      OP_MUL: begin
        if (nan_a || nan_b) task_o.fixed = CANON_NAN;
        else if (inf_a || inf_b) task_o.fixed = (z_a || z_b) ? CANON_NAN : {s, 8'hFF, 23'd0};
        else if (z_a || z_b) task_o.fixed = {s, 31'd0};
        else task_o.kind = K_MUL;
      end
      default: begin
        if (nan_a || nan_b || z_b || (inf_a && inf_b)) task_o.fixed = CANON_NAN;
        else if (inf_a) task_o.fixed = {s, 8'hFF, 23'd0};
        else if (inf_b || z_a) task_o.fixed = {s, 31'd0};
        else task_o.kind = K_DIV;
      end
    endcase
  end

endmodule

FILE: hw/rtl/fpu_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on fpu_pkg.
module fpu_queue import fpu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output task_t data_o,
  output logic  empty_o
);

  task_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  // Pointer and count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

endmodule

FILE: hw/rtl/fpu_back.sv
// Back end: passes on fixed answers, or aligns and adds, multiplies or divides, then normalises and packs.
// Depends on fpu_pkg.
module fpu_back import fpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  task_t       task_i,
  output logic        take_o,
  output logic [31:0] result_o,
  output logic        valid_o,
  input  logic        ack_i
);

  bst_e        st_q, st_d;
  task_t       t_q;
  task_t       tsw;
  logic        s_q;
  logic signed [10:0] e_q;
  logic [47:0] m_q;        // working significand (product, quotient or sum)
  logic [24:0] rem_q;
  logic [4:0]  cnt_q;
  logic [31:0] res_q;
  logic [47:0] prod;
  logic [24:0] diff;
  logic [23:0] mbs;
  logic [7:0]  d;

  assign take_o   = (st_q == S_IDLE) && !empty_i;
  assign result_o = res_q;
  assign valid_o  = (st_q == S_DONE);

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (!empty_i) begin
        unique case (task_i.kind)
          K_FIXED: st_d = S_DONE;
          K_ADD:   st_d = S_ALGN;
          K_MUL:   st_d = S_NORM;
          default: st_d = S_DIVI;
        endcase
      end
      S_ALGN: st_d = S_NORM;
      S_DIVI: if (cnt_q == 5'd0) st_d = S_NORM;
      S_NORM: if (m_q[23] || m_q == '0 || t_q.kind != K_ADD) st_d = S_PACK;
      S_PACK: st_d = S_DONE;
      S_DONE: if (ack_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_comb begin
    prod = t_q.ma * t_q.mb;
    d    = t_q.ea - t_q.eb;
    mbs  = (d >= 8'd24) ? 24'd0 : (t_q.mb >> d);
    diff = {rem_q[23:0], 1'b0} - {1'b0, t_q.mb};
    // For an add the operand with the larger exponent goes first.
    tsw  = task_i;
    if (task_i.kind == K_ADD && task_i.ea < task_i.eb) begin
      tsw.ea = task_i.eb; tsw.eb = task_i.ea;
      tsw.ma = task_i.mb; tsw.mb = task_i.ma;
      tsw.sa = task_i.sb; tsw.sb = task_i.sa;
    end
  end

  // Datapath, one step per state.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        t_q   <= tsw;
        res_q <= task_i.fixed;
        s_q   <= task_i.sa ^ task_i.sb;
        e_q   <= 11'(task_i.ea) - 11'(task_i.eb) + 11'(BIAS);
        rem_q <= {1'b0, task_i.ma};
        m_q   <= '0;
        cnt_q <= 5'd23;
      end
      S_ALGN: begin
        e_q <= 11'(t_q.ea);
        if (t_q.sa == t_q.sb) begin
          m_q <= 48'(t_q.ma) + 48'(mbs); s_q <= t_q.sa;
        end else if (t_q.ma >= mbs) begin
          m_q <= 48'(t_q.ma - mbs);
          s_q <= (t_q.ma != mbs) ? t_q.sa : 1'b0;
        end else begin
          m_q <= 48'(mbs - t_q.ma); s_q <= t_q.sb;
        end
        // Carry out of the sum is fixed in the normalise step below.
      end
      S_DIVI: begin
        // First step compares ma with mb itself, later steps shift the remainder.
        if (cnt_q == 5'd23) begin
          m_q   <= {47'd0, rem_q[23:0] >= t_q.mb};
          rem_q <= (rem_q[23:0] >= t_q.mb) ? rem_q - {1'b0, t_q.mb} : rem_q;
        end else begin
          m_q   <= {m_q[46:0], !diff[24]};
          rem_q <= diff[24] ? {rem_q[23:0], 1'b0} : diff;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      S_NORM: begin
        if (t_q.kind == K_MUL) begin
          e_q <= 11'(t_q.ea) + 11'(t_q.eb) - 11'(BIAS) + {10'd0, prod[47]};
          m_q <= prod[47] ? 48'(prod[47:24]) : 48'(prod[46:23]);
        end else if (t_q.kind == K_ADD && m_q[24]) begin
          m_q <= m_q >> 1; e_q <= e_q + 11'sd1;
        end else if (t_q.kind == K_ADD && !m_q[23] && m_q != '0) begin
          m_q <= m_q << 1; e_q <= e_q - 11'sd1;
        end else if (t_q.kind == K_DIV && !m_q[23]) begin
          m_q <= m_q << 1; e_q <= e_q - 11'sd1;
        end
      end
      S_PACK: begin
        if (m_q == '0) res_q <= 32'd0;
        else if (e_q >= 11'sd255) res_q <= {s_q, 8'hFF, 23'd0};
        else if (e_q <= 11'sd0) res_q <= {s_q, 31'd0};
        else res_q <= {s_q, e_q[7:0], m_q[22:0]};
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/fp32_add_sub_mul_div_top.sv
// Single-precision add, subtract, multiply and divide unit, top level.
// Depends on fpu_pkg, fpu_front, fpu_queue and fpu_back.
//
// Input channel: drive cmd_i, operand_a_i, operand_b_i and raise push; the
// item is taken at a clock edge where full is low. Results appear while
// empty is low and are taken by raising pop.
// The front end classifies each item in the cycle it arrives and writes it
// into a two-entry queue. The back end takes one item at a time:
//   special operands: the fixed answer goes to the result register at take;
//   multiply: take, normalise and pack; add and subtract: take, align, then
//   the normalise step once per bit of renormalising shift (up to 23), then pack;
//   divide: take, 24 restoring steps of the one-bit-per-cycle divider, normalise and pack.
// The back end handles one item until its result is popped, so a stalled
// receiver fills the queue and then raises full.
// Reset clears the queue and returns the back end to idle; no result is shown.
module fp32_add_sub_mul_div_top import fpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] result_bits_o,
  output logic        is_zero_o,
  output logic        is_infinite_o,
  output logic        is_nan_o
);

  task_t tk_in, tk_out;
  logic  q_empty, take, valid;

  fpu_front u_front (
    .cmd_i(cmd_i), .operand_a_i(operand_a_i), .operand_b_i(operand_b_i), .task_o(tk_in)
  );

  fpu_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .data_i(tk_in), .full_o(full),
    .pop_i(take), .data_o(tk_out), .empty_o(q_empty)
  );

  fpu_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .empty_i(q_empty), .task_i(tk_out), .take_o(take),
    .result_o(result_bits_o), .valid_o(valid), .ack_i(pop)
  );

  // Flags follow the packed result.
  assign empty         = !valid;
  assign is_zero_o     = (result_bits_o[30:23] == 8'h00) && (result_bits_o[22:0] == '0);
  assign is_infinite_o = (result_bits_o[30:23] == 8'hFF) && (result_bits_o[22:0] == '0);
  assign is_nan_o      = (result_bits_o[30:23] == 8'hFF) && (result_bits_o[22:0] != '0);

endmodule

FILE: hw/rtl/fpu_checker.sv
// Port-level checks for the arithmetic unit, bound to the top level.
// Depends on fp32_add_sub_mul_div_top.
module fpu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] result_bits_o,
  input logic        is_zero_o,
  input logic        is_infinite_o,
  input logic        is_nan_o
);

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_bits_o)) else $error("result changed");

  // At most one flag is set.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> $onehot0({is_zero_o, is_infinite_o, is_nan_o})) else $error("flags clash");

  // A NaN result is always the canonical one.
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_nan_o |-> result_bits_o == 32'h7FC0_0000) else $error("bad NaN");

  // A popped result leaves the output empty in the next cycle.
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop |=> empty) else $error("result repeated");

endmodule

bind fp32_add_sub_mul_div_top fpu_checker u_fpu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .empty(empty), .pop(pop),
  .result_bits_o(result_bits_o), .is_zero_o(is_zero_o),
  .is_infinite_o(is_infinite_o), .is_nan_o(is_nan_o)
);
